[design/plt_pkg.sv]
// Shared types and constants for the positional list table.
`default_nettype none
package plt_pkg;

  localparam int CAPACITY = 128;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 8;
  localparam int CMD_W    = 3;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMP_W    = ((POS_W > CNT_W) ? POS_W : CNT_W) + 2;
  localparam int CHUNK    = 8;
  localparam int CHUNK_W  = $clog2(CHUNK);
  localparam int NCHUNK   = (CAPACITY + CHUNK - 1) / CHUNK;
  localparam int MV_W     = NCHUNK * CHUNK;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT  = 3'd0,
    CMD_DEL_POS = 3'd1,
    CMD_DEL_VAL = 3'd2,
    CMD_LOCATE  = 3'd3,
    CMD_READ    = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_DEL
  } cell_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_DEL
  } state_t;

  typedef struct packed {
    cell_op_t          op;
    logic [IDX_W-1:0]  tgt;
    logic [DATA_W-1:0] data;
  } cell_ctrl_t;

endpackage
`default_nettype wire

[design/plt_cell.sv]
// One list cell: holds an entry, shifts with its neighbors, compares against the search key.
`default_nettype none
module plt_cell (
  input  wire logic                      clk,
  input  wire logic [plt_pkg::IDX_W-1:0] idx_i,
  input  wire plt_pkg::cell_ctrl_t       ctrl_i,
  input  wire logic [plt_pkg::DATA_W-1:0] lower_i,
  input  wire logic [plt_pkg::DATA_W-1:0] upper_i,
  input  wire logic [plt_pkg::DATA_W-1:0] key_i,
  input  wire logic [plt_pkg::CNT_W-1:0] count_i,
  output logic      [plt_pkg::DATA_W-1:0] val_o,
  output logic                           match_o
);

  logic [plt_pkg::DATA_W-1:0] val_r;
  logic [plt_pkg::DATA_W-1:0] val_nxt;

  always_comb begin
    val_nxt = val_r;
    case (ctrl_i.op)
      plt_pkg::CELL_INS: begin
        if (idx_i == ctrl_i.tgt) begin
          val_nxt = ctrl_i.data;
        end else if (idx_i > ctrl_i.tgt) begin
          val_nxt = lower_i;
        end
      end
      plt_pkg::CELL_DEL: begin
        if (idx_i >= ctrl_i.tgt) begin
          val_nxt = upper_i;
        end
      end
      default: val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val_o   = val_r;
  assign match_o = (val_r == key_i) && (plt_pkg::CNT_W'(idx_i) < count_i);

endmodule
`default_nettype wire

[design/positional_list_table.sv]
// Top level of the positional list table: command sequencer over a chain of list cells.
//
//   channel | ports                                   | handshake
//   --------+-----------------------------------------+------------------------------
//   input   | in_command, in_position, in_value       | start high while busy low
//   result  | out_status, out_found_position,         | out_strobe high for one cycle
//           | out_read_value, out_entry_count,        |
//           | out_is_empty                            |
//
// Insert, delete at position, read and unused codes: result in the cycle after start.
// Locate: ST_LOAD captures the match vector, then ST_SCAN scans it 8 cells a cycle until a hit or the end.
// Delete by value: as locate, then ST_DEL removes the found entry when the value is found.
// Reset clears the count and the sequencer; cell contents are written before use.
// busy is high while a locate or delete by value runs; the receiver cannot stall the result.
`default_nettype none
module positional_list_table (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic        [plt_pkg::CMD_W-1:0]  in_command,
  input  wire logic        [plt_pkg::POS_W-1:0]  in_position,
  input  wire logic signed [plt_pkg::DATA_W-1:0] in_value,
  output logic                                  out_strobe,
  output logic                                  out_status,
  output logic             [plt_pkg::POS_W-1:0]  out_found_position,
  output logic signed      [plt_pkg::DATA_W-1:0] out_read_value,
  output logic             [plt_pkg::POS_W-1:0]  out_entry_count,
  output logic                                  out_is_empty
);

  localparam int CW = plt_pkg::CMP_W;

  plt_pkg::state_t            state_r, state_nxt;
  plt_pkg::cmd_t              cmd_r, cmd_nxt;
  logic                       done_r, done_nxt;
  logic                       status_r, status_nxt;
  logic [plt_pkg::POS_W-1:0]  found_r, found_nxt;
  logic [plt_pkg::DATA_W-1:0] rdv_r, rdv_nxt;
  logic [plt_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [plt_pkg::DATA_W-1:0] key_r, key_nxt;
  logic [plt_pkg::MV_W-1:0]   mvec_r, mvec_nxt;
  logic [CW-1:0]              base_r, base_nxt;
  logic [plt_pkg::IDX_W-1:0]  fidx_r, fidx_nxt;

  plt_pkg::cell_ctrl_t        ctrl;
  logic [plt_pkg::DATA_W-1:0] vals [plt_pkg::CAPACITY];
  logic [plt_pkg::CAPACITY-1:0] mbits;

  logic [CW-1:0]               pos_ext;
  logic [CW-1:0]               cnt_ext;
  logic [plt_pkg::IDX_W-1:0]   tgt_in;
  logic                        pos_ok;
  logic                        hit;
  logic [plt_pkg::CHUNK_W-1:0] hit_j;

  genvar g;
  generate
    for (g = 0; g < plt_pkg::CAPACITY; g++) begin : g_cell
      logic [plt_pkg::DATA_W-1:0] lower;
      logic [plt_pkg::DATA_W-1:0] upper;
      if (g == 0) begin : g_first
        assign lower = ctrl.data;
      end else begin : g_mid_lo
        assign lower = vals[g-1];
      end
      if (g == plt_pkg::CAPACITY - 1) begin : g_last
        assign upper = vals[g];
      end else begin : g_mid_hi
        assign upper = vals[g+1];
      end
      plt_cell u_cell (
        .clk     (clk),
        .idx_i   (plt_pkg::IDX_W'(g)),
        .ctrl_i  (ctrl),
        .lower_i (lower),
        .upper_i (upper),
        .key_i   (key_r),
        .count_i (cnt_r),
        .val_o   (vals[g]),
        .match_o (mbits[g])
      );
    end
  endgenerate

  assign pos_ext = CW'(in_position);
  assign cnt_ext = CW'(cnt_r);
  assign tgt_in  = plt_pkg::IDX_W'(pos_ext - CW'(1));
  assign pos_ok  = (pos_ext >= CW'(1)) && (pos_ext <= cnt_ext);

  always_comb begin
    hit   = 1'b0;
    hit_j = '0;
    for (int j = plt_pkg::CHUNK - 1; j >= 0; j--) begin
      if (mvec_r[j]) begin
        hit   = 1'b1;
        hit_j = plt_pkg::CHUNK_W'(j);
      end
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    done_nxt   = 1'b0;
    status_nxt = status_r;
    found_nxt  = found_r;
    rdv_nxt    = rdv_r;
    cnt_nxt    = cnt_r;
    key_nxt    = key_r;
    mvec_nxt   = mvec_r;
    base_nxt   = base_r;
    fidx_nxt   = fidx_r;
    ctrl.op    = plt_pkg::CELL_HOLD;
    ctrl.tgt   = tgt_in;
    ctrl.data  = in_value;
    unique case (state_r)
      plt_pkg::ST_IDLE: begin
        if (start) begin
          status_nxt = 1'b1;
          found_nxt  = '0;
          rdv_nxt    = '0;
          case (in_command) inside
            plt_pkg::CMD_INSERT: begin
              done_nxt = 1'b1;
              if ((pos_ext >= CW'(1)) && (pos_ext <= cnt_ext + CW'(1)) &&
                  (cnt_ext < CW'(plt_pkg::CAPACITY))) begin
                ctrl.op    = plt_pkg::CELL_INS;
                cnt_nxt    = plt_pkg::CNT_W'(cnt_ext + CW'(1));
                status_nxt = 1'b0;
              end
            end
            plt_pkg::CMD_DEL_POS: begin
              done_nxt = 1'b1;
              if (pos_ok) begin
                ctrl.op    = plt_pkg::CELL_DEL;
                cnt_nxt    = plt_pkg::CNT_W'(cnt_ext - CW'(1));
                status_nxt = 1'b0;
              end
            end
            plt_pkg::CMD_READ: begin
              done_nxt = 1'b1;
              if (pos_ok) begin
                rdv_nxt    = vals[tgt_in];
                status_nxt = 1'b0;
              end
            end
            plt_pkg::CMD_DEL_VAL, plt_pkg::CMD_LOCATE: begin
              key_nxt   = in_value;
              cmd_nxt   = plt_pkg::cmd_t'(in_command);
              state_nxt = plt_pkg::ST_LOAD;
            end
            default: done_nxt = 1'b1;
          endcase
        end
      end
      plt_pkg::ST_LOAD: begin
        mvec_nxt  = plt_pkg::MV_W'(mbits);
        base_nxt  = '0;
        state_nxt = plt_pkg::ST_SCAN;
      end
      plt_pkg::ST_SCAN: begin
        if (hit) begin
          if (cmd_r == plt_pkg::CMD_LOCATE) begin
            found_nxt  = plt_pkg::POS_W'(base_r + CW'(hit_j) + CW'(1));
            status_nxt = 1'b0;
            done_nxt   = 1'b1;
            state_nxt  = plt_pkg::ST_IDLE;
          end else begin
            fidx_nxt  = plt_pkg::IDX_W'(base_r + CW'(hit_j));
            state_nxt = plt_pkg::ST_DEL;
          end
        end else if (base_r + CW'(plt_pkg::CHUNK) >= cnt_ext) begin
          status_nxt = 1'b1;
          done_nxt   = 1'b1;
          state_nxt  = plt_pkg::ST_IDLE;
        end else begin
          mvec_nxt = mvec_r >> plt_pkg::CHUNK;
          base_nxt = base_r + CW'(plt_pkg::CHUNK);
        end
      end
      plt_pkg::ST_DEL: begin
        ctrl.op    = plt_pkg::CELL_DEL;
        ctrl.tgt   = fidx_r;
        cnt_nxt    = plt_pkg::CNT_W'(cnt_ext - CW'(1));
        status_nxt = 1'b0;
        done_nxt   = 1'b1;
        state_nxt  = plt_pkg::ST_IDLE;
      end
      default: state_nxt = plt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= plt_pkg::ST_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    status_r <= status_nxt;
    found_r  <= found_nxt;
    rdv_r    <= rdv_nxt;
    key_r    <= key_nxt;
    mvec_r   <= mvec_nxt;
    base_r   <= base_nxt;
    fidx_r   <= fidx_nxt;
  end

  assign busy               = (state_r != plt_pkg::ST_IDLE);
  assign out_strobe         = done_r;
  assign out_status         = status_r;
  assign out_found_position = found_r;
  assign out_read_value     = rdv_r;
  assign out_entry_count    = plt_pkg::POS_W'(cnt_r);
  assign out_is_empty       = (cnt_r == '0);

endmodule
`default_nettype wire

[bench/tb_positional_list_table.sv]
`timescale 1ns / 1ps
// Self-checking testbench for positional_list_table: directed table, then phased random traffic.
module tb_positional_list_table;

  localparam logic STAT_DONE = 1'b0;
  localparam logic STAT_ERR  = 1'b1;
  localparam logic [plt_pkg::CMD_W-1:0] CMD_RSVD_LO = 3'd5;
  localparam int QUIET_LIMIT = 1000;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int NUM_PHASES = 9;

  typedef struct packed {
    logic                       status;
    logic [plt_pkg::POS_W-1:0]  found;
    logic [plt_pkg::DATA_W-1:0] rd_value;
    logic [plt_pkg::POS_W-1:0]  count;
    logic                       empty;
  } list_result_t;

  typedef struct {
    logic [plt_pkg::CMD_W-1:0]  cmd;
    logic [plt_pkg::POS_W-1:0]  pos;
    logic [plt_pkg::DATA_W-1:0] val;
    bit                         typed;
    list_result_t               res;
  } stim_row_t;

  typedef enum int {
    MIX_BALANCED,
    MIX_GROW,
    MIX_SHRINK
  } traffic_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [plt_pkg::CMD_W-1:0] in_command;
  logic [plt_pkg::POS_W-1:0] in_position;
  logic signed [plt_pkg::DATA_W-1:0] in_value;
  logic out_strobe;
  logic out_status;
  logic [plt_pkg::POS_W-1:0] out_found_position;
  logic signed [plt_pkg::DATA_W-1:0] out_read_value;
  logic [plt_pkg::POS_W-1:0] out_entry_count;
  logic out_is_empty;

  bit           stim_typed;
  list_result_t stim_res;

  logic [plt_pkg::DATA_W-1:0] shadow_list [plt_pkg::CAPACITY];
  int                shadow_count;
  list_result_t      pending_results [$];
  stim_row_t         directed_rows [$];
  int                fail_count;
  int                quiet_cycles;

  positional_list_table dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_command         (in_command),
    .in_position        (in_position),
    .in_value           (in_value),
    .out_strobe         (out_strobe),
    .out_status         (out_status),
    .out_found_position (out_found_position),
    .out_read_value     (out_read_value),
    .out_entry_count    (out_entry_count),
    .out_is_empty       (out_is_empty)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic list_result_t mk_res(input logic status,
                                          input logic [plt_pkg::POS_W-1:0] found,
                                          input logic [plt_pkg::DATA_W-1:0] rd_value,
                                          input logic [plt_pkg::POS_W-1:0] count,
                                          input logic empty);
    list_result_t r;
    r.status = status;
    r.found = found;
    r.rd_value = rd_value;
    r.count = count;
    r.empty = empty;
    return r;
  endfunction

  function automatic list_result_t apply_command(input logic [plt_pkg::CMD_W-1:0] cmd,
                                                 input logic [plt_pkg::POS_W-1:0] pos,
                                                 input logic [plt_pkg::DATA_W-1:0] val);
    list_result_t r;
    int p;
    int k;
    int hit;
    r = '0;
    r.status = STAT_ERR;
    p = pos;
    hit = 0;
    if (cmd == plt_pkg::CMD_DEL_VAL || cmd == plt_pkg::CMD_LOCATE) begin
      for (k = 0; k < shadow_count; k++) begin
        if (hit == 0 && shadow_list[k] == val) hit = k + 1;
      end
    end
    case (cmd) inside
      plt_pkg::CMD_INSERT: begin
        if (p >= 1 && p <= shadow_count + 1 && shadow_count < plt_pkg::CAPACITY) begin
          for (k = shadow_count; k > p - 1; k--) shadow_list[k] = shadow_list[k - 1];
          shadow_list[p - 1] = val;
          shadow_count++;
          r.status = STAT_DONE;
        end
      end
      plt_pkg::CMD_DEL_POS, plt_pkg::CMD_DEL_VAL: begin
        if (cmd == plt_pkg::CMD_DEL_POS && p >= 1 && p <= shadow_count) hit = p;
        if (hit != 0) begin
          for (k = hit - 1; k + 1 < shadow_count; k++) shadow_list[k] = shadow_list[k + 1];
          shadow_count--;
          r.status = STAT_DONE;
        end
      end
      plt_pkg::CMD_LOCATE: begin
        r.found = hit[plt_pkg::POS_W-1:0];
        r.status = (hit != 0) ? STAT_DONE : STAT_ERR;
      end
      plt_pkg::CMD_READ: begin
        if (p >= 1 && p <= shadow_count) begin
          r.rd_value = shadow_list[p - 1];
          r.status = STAT_DONE;
        end
      end
      default: ;
    endcase
    r.count = shadow_count[plt_pkg::POS_W-1:0];
    r.empty = (shadow_count == 0);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [plt_pkg::DATA_W-1:0] want,
                             input logic [plt_pkg::DATA_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    list_result_t want;
    if (rst_n === 1'b1) begin
      if (out_strobe === 1'b1) begin
        if (pending_results.size() == 0) begin
          $error("result with no command outstanding");
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("out_status", want.status, out_status);
          check_field("out_found_position", want.found, out_found_position);
          check_field("out_read_value", want.rd_value, out_read_value);
          check_field("out_entry_count", want.count, out_entry_count);
          check_field("out_is_empty", want.empty, out_is_empty);
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        want = apply_command(in_command, in_position, in_value);
        pending_results.push_back(stim_typed ? stim_res : want);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (start === 1'b1 && busy === 1'b0) || out_strobe === 1'b1) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic add_row(input logic [plt_pkg::CMD_W-1:0] cmd,
                         input logic [plt_pkg::POS_W-1:0] pos,
                         input logic [plt_pkg::DATA_W-1:0] val, input bit typed,
                         input list_result_t res);
    stim_row_t row;
    row.cmd = cmd;
    row.pos = pos;
    row.val = val;
    row.typed = typed;
    row.res = res;
    directed_rows.push_back(row);
  endtask

  task automatic send_command(input logic [plt_pkg::CMD_W-1:0] cmd,
                              input logic [plt_pkg::POS_W-1:0] pos,
                              input logic [plt_pkg::DATA_W-1:0] val, input bit typed,
                              input list_result_t res);
    @(negedge clk);
    start <= 1'b1;
    in_command <= cmd;
    in_position <= pos;
    in_value <= val;
    stim_typed <= typed;
    stim_res <= res;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic idle_for(input int cycles);
    @(negedge clk);
    start <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  initial begin
    traffic_t                   mode;
    int                         idle_pct;
    int                         w_ins, w_dpos, w_dval, w_loc;
    int                         r, span;
    logic [plt_pkg::CMD_W-1:0]  cmd;
    logic [plt_pkg::POS_W-1:0]  pos;
    logic [plt_pkg::DATA_W-1:0] val;

    clk = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_command = '0;
    in_position = '0;
    in_value = '0;
    stim_typed = 1'b0;
    stim_res = '0;
    shadow_count = 0;
    fail_count = 0;
    quiet_cycles = 0;

    add_row(plt_pkg::CMD_READ,    8'd1,   32'h0,         1'b1,
            mk_res(STAT_ERR,  8'd0, 32'h0, 8'd0, 1'b1));
    add_row(plt_pkg::CMD_LOCATE,  8'd0,   32'h0,         1'b1,
            mk_res(STAT_ERR,  8'd0, 32'h0, 8'd0, 1'b1));
    add_row(plt_pkg::CMD_DEL_POS, 8'd1,   32'h0,         1'b1,
            mk_res(STAT_ERR,  8'd0, 32'h0, 8'd0, 1'b1));
    add_row(plt_pkg::CMD_DEL_VAL, 8'd0,   32'h0,         1'b1,
            mk_res(STAT_ERR,  8'd0, 32'h0, 8'd0, 1'b1));
    add_row(plt_pkg::CMD_INSERT,  8'd0,   32'h5,         1'b1,
            mk_res(STAT_ERR,  8'd0, 32'h0, 8'd0, 1'b1));
    add_row(plt_pkg::CMD_INSERT,  8'd2,   32'h5,         1'b1,
            mk_res(STAT_ERR,  8'd0, 32'h0, 8'd0, 1'b1));
    add_row(plt_pkg::CMD_INSERT,  8'd1,   32'h8000_0000, 1'b1,
            mk_res(STAT_DONE, 8'd0, 32'h0, 8'd1, 1'b0));
    add_row(plt_pkg::CMD_INSERT,  8'd2,   32'h7FFF_FFFF, 1'b1,
            mk_res(STAT_DONE, 8'd0, 32'h0, 8'd2, 1'b0));
    add_row(plt_pkg::CMD_INSERT,  8'd1,   32'hFFFF_FFFF, 1'b1,
            mk_res(STAT_DONE, 8'd0, 32'h0, 8'd3, 1'b0));
    add_row(plt_pkg::CMD_READ,    8'd1,   32'h0,         1'b1,
            mk_res(STAT_DONE, 8'd0, 32'hFFFF_FFFF, 8'd3, 1'b0));
    add_row(plt_pkg::CMD_READ,    8'd3,   32'h0,         1'b1,
            mk_res(STAT_DONE, 8'd0, 32'h7FFF_FFFF, 8'd3, 1'b0));
    add_row(plt_pkg::CMD_READ,    8'd4,   32'h0,         1'b1,
            mk_res(STAT_ERR,  8'd0, 32'h0, 8'd3, 1'b0));
    add_row(plt_pkg::CMD_READ,    8'd255, 32'h0,         1'b1,
            mk_res(STAT_ERR,  8'd0, 32'h0, 8'd3, 1'b0));
    add_row(plt_pkg::CMD_LOCATE,  8'd0,   32'h7FFF_FFFF, 1'b1,
            mk_res(STAT_DONE, 8'd3, 32'h0, 8'd3, 1'b0));
    add_row(plt_pkg::CMD_LOCATE,  8'd0,   32'h0,         1'b1,
            mk_res(STAT_ERR,  8'd0, 32'h0, 8'd3, 1'b0));
    add_row(plt_pkg::CMD_INSERT,  8'd4,   32'h0,         1'b1,
            mk_res(STAT_DONE, 8'd0, 32'h0, 8'd4, 1'b0));
    add_row(plt_pkg::CMD_INSERT,  8'd2,   32'h0,         1'b0, '0);
    add_row(plt_pkg::CMD_LOCATE,  8'd0,   32'h0,         1'b0, '0);
    add_row(plt_pkg::CMD_DEL_VAL, 8'd0,   32'h0,         1'b0, '0);
    add_row(plt_pkg::CMD_DEL_VAL, 8'd0,   32'h1234_5678, 1'b1,
            mk_res(STAT_ERR,  8'd0, 32'h0, 8'd4, 1'b0));
    add_row(CMD_RSVD_LO,        8'd1,   32'h0,  1'b1, mk_res(STAT_ERR,  8'd0, 32'h0, 8'd4, 1'b0));
    add_row(CMD_RSVD_LO + 3'd1, 8'd0,   32'h0,  1'b1, mk_res(STAT_ERR,  8'd0, 32'h0, 8'd4, 1'b0));
    add_row(CMD_RSVD_LO + 3'd2, 8'd255, 32'hFFFF_FFFF, 1'b1,
            mk_res(STAT_ERR, 8'd0, 32'h0, 8'd4, 1'b0));
    add_row(plt_pkg::CMD_DEL_POS, 8'd0,   32'h0,         1'b1,
            mk_res(STAT_ERR,  8'd0, 32'h0, 8'd4, 1'b0));
    add_row(plt_pkg::CMD_DEL_POS, 8'd4,   32'h0,         1'b0, '0);
    add_row(plt_pkg::CMD_DEL_POS, 8'd1,   32'h0,         1'b0, '0);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      send_command(directed_rows[i].cmd, directed_rows[i].pos, directed_rows[i].val,
                   directed_rows[i].typed, directed_rows[i].res);
    end
    drain_results();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase % 4)
        1:       mode = MIX_GROW;
        3:       mode = MIX_SHRINK;
        default: mode = MIX_BALANCED;
      endcase
      case (mode)
        MIX_GROW:   begin w_ins = 88; w_dpos = 3;  w_dval = 3;  w_loc = 3;  end
        MIX_SHRINK: begin w_ins = 4;  w_dpos = 46; w_dval = 40; w_loc = 5;  end
        default:    begin w_ins = 35; w_dpos = 13; w_dval = 15; w_loc = 17; end
      endcase
      idle_pct = (phase >= NUM_PHASES - 2) ? 0 :
                 ((phase % 3 == 0) ? 0 : 8 + 17 * (phase % 3 - 1));

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        r = $urandom_range(0, 99);
        if (r < 4) begin
          cmd = CMD_RSVD_LO + 3'($urandom_range(0, 2));
        end else begin
          r = $urandom_range(0, 99);
          if (r < w_ins) cmd = plt_pkg::CMD_INSERT;
          else if (r < w_ins + w_dpos) cmd = plt_pkg::CMD_DEL_POS;
          else if (r < w_ins + w_dpos + w_dval) cmd = plt_pkg::CMD_DEL_VAL;
          else if (r < w_ins + w_dpos + w_dval + w_loc) cmd = plt_pkg::CMD_LOCATE;
          else cmd = plt_pkg::CMD_READ;
        end

        span = (cmd == plt_pkg::CMD_INSERT) ? shadow_count + 1 : shadow_count;
        r = $urandom_range(0, 99);
        if (r < 8 || span == 0) pos = 8'($urandom_range(0, 255));
        else if (r < 10) pos = '0;
        else if (r < 12) pos = 8'(span + 1);
        else pos = 8'($urandom_range(1, span));

        r = $urandom_range(0, 99);
        if (r < 30 && shadow_count > 0) val = shadow_list[$urandom_range(0, shadow_count - 1)];
        else if (r < 50) val = 32'($urandom_range(0, 7));
        else if (r < 56) begin
          case ($urandom_range(0, 3))
            0:       val = 32'h8000_0000;
            1:       val = 32'h7FFF_FFFF;
            2:       val = 32'hFFFF_FFFF;
            default: val = 32'h0;
          endcase
        end else val = $urandom;

        send_command(cmd, pos, val, 1'b0, '0);
        if ($urandom_range(0, 99) < idle_pct) idle_for($urandom_range(1, 9));
      end
      drain_results();
    end

    repeat (24) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[filelist.f]
design/plt_pkg.sv
design/plt_cell.sv
design/positional_list_table.sv
bench/tb_positional_list_table.sv
